@@ rtl/core/hsv2rgb_pkg.sv @@
package hsv2rgb_pkg;

  // Hue fixed point: fraction bits per degree
  localparam int HUE_FRAC_BITS = 5;

  // One 60 degree sector and one full turn in hue units
  localparam int SECTOR_LEN = 60 << HUE_FRAC_BITS;
  localparam int TURN_LEN   = 6 * SECTOR_LEN;

  // Whole turns added so that any signed 16-bit hue becomes non-negative
  localparam int HUE_OFS = ((32768 + TURN_LEN - 1) / TURN_LEN) * TURN_LEN;
  localparam int UW      = $clog2(32767 + HUE_OFS + 1);
  localparam int PW      = $clog2(SECTOR_LEN);
  localparam int HQ_MAX  = (32767 + HUE_OFS) / SECTOR_LEN;
  localparam int HQW     = $clog2(HQ_MAX + 1);

  // Exact reciprocal of the sector length for UW-bit dividends
  localparam int HQ_SHIFT = UW + PW;
  localparam int MHW      = UW + 1;
  localparam logic [MHW-1:0] RECIP_SECTOR =
    MHW'(((64'd1 << HQ_SHIFT) + SECTOR_LEN - 1) / SECTOR_LEN);

  // Channel divisor 255 * sector length and its exact reciprocal
  localparam longint unsigned DEN = 255 * SECTOR_LEN;
  localparam int DW       = $clog2(DEN + 1);
  localparam int NW       = DW + 8;
  localparam int CH_SHIFT = NW + DW;
  localparam int MCW      = NW + 1;
  localparam logic [MCW-1:0] RECIP_DEN =
    MCW'(((64'd1 << CH_SHIFT) + DEN - 1) / DEN);

  // Register stages from an accepted word to its result strobe
  localparam int PIPE_DEPTH = 6;

  // Hue sectors, named by the colours they span
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef struct packed {
    logic signed [15:0] hue;
    logic [7:0]         saturation;
    logic [7:0]         brightness;
    logic [7:0]         alpha_in;
  } hsv_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha_out;
  } rgb_word_t;

  // Whole-sector count modulo six, as a small constant table
  function automatic sector_t sector_of(input logic [HQW-1:0] hq);
    sector_t sec;
    sector_t cnt;
    sec = SEC_RY;
    cnt = SEC_RY;
    for (int i = 0; i < (1 << HQW); i++) begin
      if (hq == HQW'(i)) sec = cnt;
      cnt = (cnt == SEC_MR) ? SEC_RY : sector_t'(cnt + 3'd1);
    end
    return sec;
  endfunction

endpackage

@@ rtl/core/hsv_to_rgb_convert.sv @@
// Channel  Handshake            Word
// -------  -------------------  ----------------------------------------------
// in       start / busy         hsv: hue, saturation, brightness, alpha_in
// out      done (1-cycle pulse) rgb: red, green, blue, alpha_out
//
// One word per clock while busy is low; each result is carried to done and rgb
// through the six register stages of the datapath (PIPE_DEPTH).
// The deepest stage is the 27 x 28 bit reciprocal multiply of each channel.
// rst is synchronous and clears every valid bit; busy is high during reset.
// Results cannot be held off, so the pipeline never stalls.
module hsv_to_rgb_convert (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  hsv2rgb_pkg::hsv_word_t hsv,
  output logic                   done,
  output hsv2rgb_pkg::rgb_word_t rgb
);

  // Stage 1: offset hue, quotient by sector length
  logic                                   v1;
  logic [hsv2rgb_pkg::UW-1:0]             s1_u;
  logic [hsv2rgb_pkg::HQW-1:0]            s1_hq;
  logic [7:0]                             s1_sat, s1_bri, s1_alpha;
  logic [hsv2rgb_pkg::UW-1:0]             hue_u;
  logic [hsv2rgb_pkg::UW+hsv2rgb_pkg::MHW-1:0] hue_prod;

  // Stage 2: fraction and sector
  logic                                   v2;
  logic [hsv2rgb_pkg::PW-1:0]             s2_rem;
  hsv2rgb_pkg::sector_t                   s2_sec;
  logic [7:0]                             s2_sat, s2_bri, s2_alpha;
  logic [hsv2rgb_pkg::UW-1:0]             rem_full;

  // Stage 3: numerators over 255 * sector length
  logic                                   v3;
  logic [hsv2rgb_pkg::DW-1:0]             s3_np, s3_nq, s3_nt;
  hsv2rgb_pkg::sector_t                   s3_sec;
  logic [7:0]                             s3_bri, s3_alpha;
  logic [hsv2rgb_pkg::PW+7:0]             sat_r, sat_pr;
  logic [hsv2rgb_pkg::PW-1:0]             p_minus_r;

  // Stage 4: brightness products
  logic                                   v4;
  logic [hsv2rgb_pkg::NW-1:0]             s4_mp, s4_mq, s4_mt;
  hsv2rgb_pkg::sector_t                   s4_sec;
  logic [7:0]                             s4_bri, s4_alpha;

  // Stage 5: channel quotients
  logic                                   v5;
  logic [7:0]                             s5_p, s5_q, s5_t;
  hsv2rgb_pkg::sector_t                   s5_sec;
  logic [7:0]                             s5_bri, s5_alpha;
  logic [hsv2rgb_pkg::NW+hsv2rgb_pkg::MCW-1:0] dp, dq, dt;

  logic                                   accept;
  hsv2rgb_pkg::rgb_word_t                 rgb_next;

  assign busy   = rst;
  assign accept = start && !busy;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      done <= v5;
    end
  end

  // Hue made non-negative by whole turns, then divided by the sector length
  assign hue_u    = hsv2rgb_pkg::UW'(hsv.hue) + hsv2rgb_pkg::UW'(hsv2rgb_pkg::HUE_OFS);
  assign hue_prod = hue_u * hsv2rgb_pkg::RECIP_SECTOR;

  always_ff @(posedge clk) begin
    s1_u     <= hue_u;
    s1_hq    <= hue_prod[hsv2rgb_pkg::HQ_SHIFT +: hsv2rgb_pkg::HQW];
    s1_sat   <= hsv.saturation;
    s1_bri   <= hsv.brightness;
    s1_alpha <= hsv.alpha_in;
  end

  // Remainder within the sector
  assign rem_full = s1_u - hsv2rgb_pkg::UW'(s1_hq * hsv2rgb_pkg::SECTOR_LEN);

  always_ff @(posedge clk) begin
    s2_rem   <= rem_full[hsv2rgb_pkg::PW-1:0];
    s2_sec   <= hsv2rgb_pkg::sector_of(s1_hq);
    s2_sat   <= s1_sat;
    s2_bri   <= s1_bri;
    s2_alpha <= s1_alpha;
  end

  // p, q, t numerators, all scaled to the common divisor
  assign p_minus_r = hsv2rgb_pkg::PW'(hsv2rgb_pkg::SECTOR_LEN) - s2_rem;
  assign sat_r     = s2_sat * s2_rem;
  assign sat_pr    = s2_sat * p_minus_r;

  always_ff @(posedge clk) begin
    s3_np    <= hsv2rgb_pkg::DW'((8'd255 - s2_sat) * hsv2rgb_pkg::SECTOR_LEN);
    s3_nq    <= hsv2rgb_pkg::DW'(hsv2rgb_pkg::DEN) - hsv2rgb_pkg::DW'(sat_r);
    s3_nt    <= hsv2rgb_pkg::DW'(hsv2rgb_pkg::DEN) - hsv2rgb_pkg::DW'(sat_pr);
    s3_sec   <= s2_sec;
    s3_bri   <= s2_bri;
    s3_alpha <= s2_alpha;
  end

  // Scale by brightness
  always_ff @(posedge clk) begin
    s4_mp    <= s3_bri * s3_np;
    s4_mq    <= s3_bri * s3_nq;
    s4_mt    <= s3_bri * s3_nt;
    s4_sec   <= s3_sec;
    s4_bri   <= s3_bri;
    s4_alpha <= s3_alpha;
  end

  // Exact floor division by 255 * sector length via reciprocal
  assign dp = s4_mp * hsv2rgb_pkg::RECIP_DEN;
  assign dq = s4_mq * hsv2rgb_pkg::RECIP_DEN;
  assign dt = s4_mt * hsv2rgb_pkg::RECIP_DEN;

  always_ff @(posedge clk) begin
    s5_p     <= dp[hsv2rgb_pkg::CH_SHIFT +: 8];
    s5_q     <= dq[hsv2rgb_pkg::CH_SHIFT +: 8];
    s5_t     <= dt[hsv2rgb_pkg::CH_SHIFT +: 8];
    s5_sec   <= s4_sec;
    s5_bri   <= s4_bri;
    s5_alpha <= s4_alpha;
  end

  // Sector routing; zero saturation makes p = q = t = v, so grey falls out
  always_comb begin
    rgb_next.alpha_out = s5_alpha;
    case (s5_sec)
      hsv2rgb_pkg::SEC_RY: begin
        rgb_next.red = s5_bri; rgb_next.green = s5_t;   rgb_next.blue = s5_p;
      end
      hsv2rgb_pkg::SEC_YG: begin
        rgb_next.red = s5_q;   rgb_next.green = s5_bri; rgb_next.blue = s5_p;
      end
      hsv2rgb_pkg::SEC_GC: begin
        rgb_next.red = s5_p;   rgb_next.green = s5_bri; rgb_next.blue = s5_t;
      end
      hsv2rgb_pkg::SEC_CB: begin
        rgb_next.red = s5_p;   rgb_next.green = s5_q;   rgb_next.blue = s5_bri;
      end
      hsv2rgb_pkg::SEC_BM: begin
        rgb_next.red = s5_t;   rgb_next.green = s5_p;   rgb_next.blue = s5_bri;
      end
      default: begin
        rgb_next.red = s5_bri; rgb_next.green = s5_p;   rgb_next.blue = s5_q;
      end
    endcase
  end

  // Output word register
  always_ff @(posedge clk) begin
    rgb <= rgb_next;
  end

`ifndef ASSERT_OFF
  // Last stage always reaches the output strobe
  a_valid_chain: assert property (@(posedge clk) disable iff (rst)
    v5 |=> done)
    else $error("stage 5 word lost before output");

  // Fraction stays inside one sector
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (s2_rem < hsv2rgb_pkg::PW'(hsv2rgb_pkg::SECTOR_LEN)))
    else $error("sector remainder out of range");

  // Alpha arrives with its own word
  a_alpha_pass: assert property (@(posedge clk) disable iff (rst)
    done |-> (rgb.alpha_out == $past(hsv.alpha_in, hsv2rgb_pkg::PIPE_DEPTH)))
    else $error("alpha misaligned with colour");

  // Zero saturation gives grey at the input brightness
  a_grey: assert property (@(posedge clk) disable iff (rst)
    (done && $past(hsv.saturation == 8'd0, hsv2rgb_pkg::PIPE_DEPTH)) |->
      (rgb.red == rgb.green && rgb.green == rgb.blue &&
       rgb.red == $past(hsv.brightness, hsv2rgb_pkg::PIPE_DEPTH)))
    else $error("zero saturation not grey");
`endif

endmodule
